// ===== rtl/swpc_pkg.sv =====
package swpc_pkg;

  // Price width in ticks
  localparam int PRICE_BITS = 32;
  // Window registers are 7 bits wide
  localparam int WIN_BITS   = 7;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_WINDOW  = 2'd3;

  // Reset values of the windows
  localparam logic [WIN_BITS-1:0] ENTRY_WINDOW_RST = 7'd20;
  localparam logic [WIN_BITS-1:0] TRAIL_WINDOW_RST = 7'd10;
  localparam logic [WIN_BITS-1:0] STOP_WINDOW_RST  = 7'd10;

  typedef struct packed {
    logic [PRICE_BITS-1:0] low_price;
    logic [PRICE_BITS-1:0] high_price;
  } in_t;

  typedef struct packed {
    logic [PRICE_BITS-1:0] entry_level;
    logic                  entry_valid;
    logic [PRICE_BITS-1:0] trail_level;
    logic                  trail_valid;
    logic [PRICE_BITS-1:0] stop_level;
    logic                  stop_valid;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture bar, start scan
    logic issue;   // one history read
    logic commit;  // store levels, write bar into history
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_issue;  // the oldest slot is being read
  } stat_t;

endpackage

// ===== rtl/swpc_ram.sv =====
module swpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/swpc_ctrl.sv =====
module swpc_ctrl
  import swpc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_vld_r;

  // Commands
  always_comb begin
    cmd.load   = in_valid && (state_r == S_IDLE);
    cmd.issue  = (state_r == S_SCAN);
    cmd.commit = (state_r == S_COMMIT) && (!out_vld_r || out_ready);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (cmd.load) state_nxt = S_SCAN;
      S_SCAN:   if (stat.last_issue) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = S_COMMIT;
      S_COMMIT: if (cmd.commit) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Output register holds until transfer
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.commit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

// ===== rtl/swpc_dp.sv =====
module swpc_dp
  import swpc_pkg::*;
#(
  parameter int WINDOW_MAX = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [WIN_BITS-1:0]  cfg_data,
  input  in_t                  in_data,
  output out_t                 out_data,
  input  cmd_t                 cmd,
  output stat_t                stat
);

  localparam int AW    = $clog2(WINDOW_MAX);
  localparam int KW    = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W = (KW > WIN_BITS) ? KW : WIN_BITS;

  localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_MAX - 1);
  localparam logic [KW-1:0] K_LAST   = KW'(WINDOW_MAX);

  // Configuration
  logic                short_mode_r;
  logic [WIN_BITS-1:0] entry_win_r, trail_win_r, stop_win_r;

  // History bookkeeping
  logic [AW-1:0] wp_r;
  logic [KW-1:0] bars_r;

  // Scan state
  in_t           bar_r;
  logic [AW-1:0] rd_ptr_r;
  logic [KW-1:0] k_r, kd_r;
  logic          rd_vld_r;
  logic [PRICE_BITS-1:0] entry_acc_r, trail_acc_r, stop_acc_r;
  logic [PRICE_BITS-1:0] entry_acc_nxt, trail_acc_nxt, stop_acc_nxt;

  logic [PRICE_BITS-1:0] low_rd, high_rd;
  out_t                  out_r;
  out_t                  res;

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // a <= b over common width
  function automatic logic not_above(input logic [CMP_W-1:0] a,
                                     input logic [CMP_W-1:0] b);
    not_above = (a <= b);
  endfunction

  assign stat.last_issue = cmd.issue && (k_r == K_LAST);

  // History rings
  swpc_ram #(.WIDTH(PRICE_BITS), .DEPTH(WINDOW_MAX)) u_low_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (wp_r),
    .wdata (bar_r.low_price),
    .raddr (rd_ptr_r),
    .rdata (low_rd)
  );

  swpc_ram #(.WIDTH(PRICE_BITS), .DEPTH(WINDOW_MAX)) u_high_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (wp_r),
    .wdata (bar_r.high_price),
    .raddr (rd_ptr_r),
    .rdata (high_rd)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_mode_r <= 1'b0;
      entry_win_r  <= ENTRY_WINDOW_RST;
      trail_win_r  <= TRAIL_WINDOW_RST;
      stop_win_r   <= STOP_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SHORT_MODE:   short_mode_r <= cfg_data[0];
        CFG_ENTRY_WINDOW: entry_win_r  <= cfg_data;
        CFG_TRAIL_WINDOW: trail_win_r  <= cfg_data;
        CFG_STOP_WINDOW:  stop_win_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accumulator update; entry takes max high in long mode, min low in short
  always_comb begin
    logic entry_in, trail_in, stop_in;
    logic [PRICE_BITS-1:0] entry_src, other_src;
    logic entry_better, trail_better, stop_better;
    entry_acc_nxt = entry_acc_r;
    trail_acc_nxt = trail_acc_r;
    stop_acc_nxt  = stop_acc_r;
    entry_in  = not_above(CMP_W'(kd_r), CMP_W'(entry_win_r));
    trail_in  = not_above(CMP_W'(kd_r), CMP_W'(trail_win_r));
    stop_in   = not_above(CMP_W'(kd_r), CMP_W'(stop_win_r));
    entry_src = short_mode_r ? low_rd : high_rd;
    other_src = short_mode_r ? high_rd : low_rd;
    entry_better = short_mode_r ? (entry_src < entry_acc_r) : (entry_src > entry_acc_r);
    trail_better = short_mode_r ? (other_src > trail_acc_r) : (other_src < trail_acc_r);
    stop_better  = short_mode_r ? (other_src > stop_acc_r)  : (other_src < stop_acc_r);
    if (cmd.load) begin
      entry_acc_nxt = short_mode_r ? in_data.low_price  : in_data.high_price;
      trail_acc_nxt = short_mode_r ? in_data.high_price : in_data.low_price;
      stop_acc_nxt  = trail_acc_nxt;
    end else if (rd_vld_r) begin
      if (entry_in && entry_better) entry_acc_nxt = entry_src;
      if (trail_in && trail_better) trail_acc_nxt = other_src;
      if (stop_in && stop_better)   stop_acc_nxt  = other_src;
    end
  end

  // Levels are zero until enough bars have been stored
  always_comb begin
    res.entry_valid = not_above(CMP_W'(entry_win_r), CMP_W'(bars_r));
    res.trail_valid = not_above(CMP_W'(trail_win_r), CMP_W'(bars_r));
    res.stop_valid  = not_above(CMP_W'(stop_win_r), CMP_W'(bars_r));
    res.entry_level = res.entry_valid ? entry_acc_r : '0;
    res.trail_level = res.trail_valid ? trail_acc_r : '0;
    res.stop_level  = res.stop_valid  ? stop_acc_r  : '0;
  end

  // Scan registers
  always_ff @(posedge clk) begin
    entry_acc_r <= entry_acc_nxt;
    trail_acc_r <= trail_acc_nxt;
    stop_acc_r  <= stop_acc_nxt;
    if (cmd.load) begin
      bar_r    <= in_data;
      k_r      <= KW'(1);
      rd_ptr_r <= ptr_dec(wp_r);
    end else if (cmd.issue) begin
      k_r      <= k_r + 1'b1;
      rd_ptr_r <= ptr_dec(rd_ptr_r);
    end
    if (cmd.issue) begin
      kd_r <= k_r;
    end
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      wp_r     <= '0;
      bars_r   <= '0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cmd.commit) begin
        wp_r <= ptr_inc(wp_r);
        if (bars_r != K_LAST) begin
          bars_r <= bars_r + 1'b1;
        end
      end
    end
  end

  assign out_data = out_r;

endmodule

// ===== rtl/sliding_window_price_channels.sv =====
// Each bar is captured, scans every history slot through one registered read port
// of the rings, then writes itself back; the next bar is accepted only after that.
// A result waiting in the output register stalls the next bar at its write-back.
// Reset (rst_n low, synchronous) empties the history count and pointer and loads
// the register defaults; ring contents are not cleared.
module sliding_window_price_channels
  import swpc_pkg::*;
#(
  parameter int WINDOW_MAX = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [WIN_BITS-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data
);

  cmd_t  cmd;
  stat_t stat;

  swpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  swpc_dp #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ===== tb/sv/sliding_window_price_channels_test.sv =====
`timescale 1ns / 100ps

module sliding_window_price_channels_test;
  import swpc_pkg::*;

  localparam int RING_DEPTH       = 64;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 80;
  localparam int RANDOM_PHASES    = 12;

  // Tracks price history and window settings, predicts channel levels per bar
  class level_scoreboard;
    logic [PRICE_BITS-1:0] low_ring [RING_DEPTH];
    logic [PRICE_BITS-1:0] high_ring [RING_DEPTH];
    int unsigned next_slot;
    int unsigned bars_stored;
    bit          short_pos;
    int unsigned entry_win;
    int unsigned trail_win;
    int unsigned stop_win;
    out_t        levels_due [$];
    int unsigned errors;

    function new();
      next_slot   = 0;
      bars_stored = 0;
      short_pos   = 1'b0;
      entry_win   = ENTRY_WINDOW_RST;
      trail_win   = TRAIL_WINDOW_RST;
      stop_win    = STOP_WINDOW_RST;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [WIN_BITS-1:0] val);
      case (idx)
        CFG_SHORT_MODE:   short_pos = val[0];
        CFG_ENTRY_WINDOW: entry_win = val;
        CFG_TRAIL_WINDOW: trail_win = val;
        CFG_STOP_WINDOW:  stop_win  = val;
      endcase
    endfunction

    // Max over highs or min over lows: current bar plus the last win stored bars.
    // Not valid (level zero) until win bars are in the ring.
    function void window_extreme(input bit use_max, input logic [PRICE_BITS-1:0] cur,
                                 input int unsigned win,
                                 output logic [PRICE_BITS-1:0] level, output logic ok);
      logic [PRICE_BITS-1:0] v;
      int unsigned slot;
      level = '0;
      ok    = 1'b0;
      if (win <= bars_stored) begin
        level = cur;
        for (int unsigned k = 1; k <= win; k++) begin
          slot = (next_slot + RING_DEPTH - k) % RING_DEPTH;
          v = use_max ? high_ring[slot] : low_ring[slot];
          if (use_max ? (v > level) : (v < level)) level = v;
        end
        ok = 1'b1;
      end
    endfunction

    // Input transfer: queue the levels this bar produces, then store the bar
    function void note_bar(in_t bar);
      logic [PRICE_BITS-1:0] lvl;
      logic ok;
      out_t lv;
      window_extreme(!short_pos, short_pos ? bar.low_price : bar.high_price,
                     entry_win, lvl, ok);
      lv.entry_level = lvl;
      lv.entry_valid = ok;
      window_extreme(short_pos, short_pos ? bar.high_price : bar.low_price,
                     trail_win, lvl, ok);
      lv.trail_level = lvl;
      lv.trail_valid = ok;
      window_extreme(short_pos, short_pos ? bar.high_price : bar.low_price,
                     stop_win, lvl, ok);
      lv.stop_level = lvl;
      lv.stop_valid = ok;
      levels_due.push_back(lv);
      low_ring[next_slot]  = bar.low_price;
      high_ring[next_slot] = bar.high_price;
      next_slot = (next_slot + 1) % RING_DEPTH;
      if (bars_stored < RING_DEPTH) bars_stored++;
    endfunction

    function void check_field(string name, logic [PRICE_BITS-1:0] want,
                              logic [PRICE_BITS-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
    endfunction

    // Output transfer: compare against the oldest pending level set
    function void check_levels(out_t got);
      out_t want;
      if (levels_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, got %p", $time, got);
        return;
      end
      want = levels_due.pop_front();
      check_field("entry_level", want.entry_level, got.entry_level);
      check_field("entry_valid", want.entry_valid, got.entry_valid);
      check_field("trail_level", want.trail_level, got.trail_level);
      check_field("trail_valid", want.trail_valid, got.trail_valid);
      check_field("stop_level",  want.stop_level,  got.stop_level);
      check_field("stop_valid",  want.stop_valid,  got.stop_valid);
    endfunction

    function int unsigned pending();
      return levels_due.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_SHORT_MODE;
  logic [WIN_BITS-1:0]  cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;

  level_scoreboard tracker = new();

  // Idle control shared by the sender, the receiver and the phase sequence
  bit tx_eager    = 1'b0;
  bit rx_eager    = 1'b0;
  bit rx_hold_req = 1'b0;

  logic [PRICE_BITS-1:0] prev_low  = '0;
  logic [PRICE_BITS-1:0] prev_high = '0;

  sliding_window_price_channels DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Transfer monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_bar(in_data);
      if (out_valid && out_ready) tracker.check_levels(out_data);
    end
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_req) begin
        stall = LONG_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else begin
        stall = rx_eager ? 0 : $urandom_range(0, 3);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("sliding_window_price_channels_test: done, errors");
    $finish;
  end

  // Offer one bar after a random gap; returns at the step of its transfer.
  // valid is left high so a back-to-back bar needs no second assignment.
  task automatic send_bar(input in_t bar);
    int unsigned gap;
    gap = tx_eager ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= bar;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every pending level set is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges
  task automatic program_channels(input logic [WIN_BITS-1:0] mode_val,
                                  input logic [WIN_BITS-1:0] ew,
                                  input logic [WIN_BITS-1:0] tw,
                                  input logic [WIN_BITS-1:0] sw);
    logic [CFG_IDX_W-1:0] regs [4];
    logic [WIN_BITS-1:0]  vals [4];
    regs = '{CFG_SHORT_MODE, CFG_ENTRY_WINDOW, CFG_TRAIL_WINDOW, CFG_STOP_WINDOW};
    vals = '{mode_val, ew, tw, sw};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      tracker.set_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Bars at the price extremes and alternating bit patterns
  function automatic in_t corner_bar(int i);
    case (i)
      0:       return {32'h0000_0000, 32'hFFFF_FFFF};
      1:       return {32'hFFFF_FFFF, 32'h0000_0000};
      2:       return {32'h8000_0000, 32'h7FFF_FFFF};
      3:       return {32'hFFFF_FFFF, 32'hFFFF_FFFF};
      4:       return {32'h0000_0000, 32'h0000_0000};
      5:       return {32'hAAAA_AAAA, 32'h5555_5555};
      6:       return {32'h5555_5555, 32'hAAAA_AAAA};
      default: return {32'h0000_0001, 32'hFFFF_FFFE};
    endcase
  endfunction

  // Mix of full-range values, extremes, ties and small walks
  function automatic logic [PRICE_BITS-1:0] next_price(logic [PRICE_BITS-1:0] prev);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return prev + $urandom_range(0, 64) - 32;
      4:       return prev;
      5:       return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  // Windows weighted toward zero, one, the ring size and values past it
  function automatic logic [WIN_BITS-1:0] pick_window();
    case ($urandom_range(0, 7))
      0:       return 7'd0;
      1:       return 7'd64;
      2:       return 7'd1;
      3:       return 7'd63;
      4:       return WIN_BITS'($urandom_range(65, 127));
      default: return WIN_BITS'($urandom_range(0, 64));
    endcase
  endfunction

  // Phase sequence
  initial begin
    in_t bar;
    int unsigned n_items;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults, history too short for any window
    for (int i = 0; i < 8; i++) send_bar(corner_bar(i));
    settle();

    // long mode, window zero and short windows
    program_channels(7'd0, 7'd0, 7'd1, 7'd2);
    for (int i = 0; i < 8; i++) send_bar(corner_bar(i));
    settle();

    // short mode via a write with upper bits set, window past the ring
    program_channels(7'h7F, 7'd3, 7'd0, 7'd127);
    for (int i = 0; i < 8; i++) send_bar(corner_bar(i));
    settle();

    // random bars under a series of window settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      case (p)
        0:       program_channels(7'd0, 7'd64, 7'd64, 7'd64);
        1:       program_channels(7'd1, 7'd0, 7'd0, 7'd0);
        2:       program_channels(WIN_BITS'($urandom_range(0, 127)), 7'd127, 7'd65,
                                  7'd127);
        default: program_channels(WIN_BITS'($urandom_range(0, 127)), pick_window(),
                                  pick_window(), pick_window());
      endcase
      // long receiver hold-off while bars keep coming
      if (p == 4) rx_hold_req = 1'b1;
      n_items = 150 + $urandom_range(0, 10);
      repeat (n_items) begin
        prev_low  = next_price(prev_low);
        prev_high = next_price(prev_high);
        bar.low_price  = prev_low;
        bar.high_price = prev_high;
        send_bar(bar);
      end
      settle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("sliding_window_price_channels_test: done, clean");
    end else begin
      $display("sliding_window_price_channels_test: done, errors");
    end
    $finish;
  end

endmodule
